/* hdl/kcr_pkg.sv */
// Package with shared constants, register indexes and command types of the key chord remapper.
`default_nettype none
package kcr_pkg;

   localparam int unsigned CODE_W = 10;
   localparam int unsigned TYPE_W = 5;
   localparam int unsigned THR_W  = 7;
   localparam int unsigned CNT_W  = 8;
   localparam int unsigned REP_W  = 2;

   // Held-back modifier presses, and the most presses flushed ahead of a release.
   localparam logic [REP_W-1:0] PENDING_MAX = 2'd2;
   localparam logic [REP_W-1:0] FLUSH_MAX   = 2'd2;

   localparam logic [TYPE_W-1:0] DEFAULT_TYPE = 5'd1;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      REG_MODIFIER   = 3'd0,
      REG_VOL_DOWN   = 3'd1,
      REG_VOL_UP     = 3'd2,
      REG_POWER      = 3'd3,
      REG_ALT_DOWN   = 3'd4,
      REG_ALT_UP     = 3'd5,
      REG_ALT_POWER  = 3'd6,
      REG_RESTART    = 3'd7
   } csr_index_type;

   // One classified request: rep presses of code, then one final result.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [TYPE_W-1:0] evt;
      logic [REP_W-1:0]  rep;
      logic              final_value;
      logic              final_restart;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage
`default_nettype wire

/* hdl/kcr_req_if.sv */
// Request channel interface: key report with valid/ready handshake.
`default_nettype none
interface kcr_req_if;
   logic                         valid;
   logic                         ready;
   logic [kcr_pkg::CODE_W-1:0]   key_code;
   logic [kcr_pkg::TYPE_W-1:0]   event_type;
   logic                         pressed;

   modport source (output valid, key_code, event_type, pressed, input ready);
   modport sink   (input valid, key_code, event_type, pressed, output ready);
endinterface
`default_nettype wire

/* hdl/kcr_rsp_if.sv */
// Response channel interface: emitted key event with valid/ready handshake.
`default_nettype none
interface kcr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [kcr_pkg::CODE_W-1:0]   out_code;
   logic [kcr_pkg::TYPE_W-1:0]   out_type;
   logic                         out_value;
   logic                         restart_request;
   logic                         last;

   modport source (output valid, out_code, out_type, out_value, restart_request, last,
                   input ready);
   modport sink   (input valid, out_code, out_type, out_value, restart_request, last,
                   output ready);
endinterface
`default_nettype wire

/* hdl/kcr_front.sv */
// Front end: configuration registers, key classification and chord/counter state.
`default_nettype none
module kcr_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   kcr_req_if.sink                            req_chan,
   input  wire logic                          csr_write_enable,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [kcr_pkg::CODE_W-1:0]    csr_write_data,
   input  wire logic                          push_ready,
   output logic                               push_valid,
   output kcr_pkg::cmd_type                   push_cmd
);

   logic [kcr_pkg::CODE_W-1:0] mod_code_ff, dn_code_ff, up_code_ff, pw_code_ff;
   logic [kcr_pkg::CODE_W-1:0] alt_dn_ff, alt_up_ff, alt_pw_ff;
   logic [kcr_pkg::THR_W-1:0]  thr_ff;

   logic [kcr_pkg::REP_W-1:0]  pending_ff, pending_in;
   logic                       chord_ff, chord_in;
   logic signed [kcr_pkg::CNT_W-1:0] down_cnt_ff, down_cnt_in;
   logic signed [kcr_pkg::CNT_W-1:0] pwr_cnt_ff, pwr_cnt_in;

   logic                       accept;
   logic                       is_mod, is_dn, is_up, is_pw;
   logic [kcr_pkg::TYPE_W-1:0] evt;
   logic signed [kcr_pkg::CNT_W-1:0] thr_s;

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_code_ff <= 10'd158;
         dn_code_ff  <= 10'd102;
         up_code_ff  <= 10'd108;
         pw_code_ff  <= 10'd139;
         alt_dn_ff   <= 10'd114;
         alt_up_ff   <= 10'd115;
         alt_pw_ff   <= 10'd217;
         thr_ff      <= 7'd10;
      end else if (csr_write_enable) begin
         case (kcr_pkg::csr_index_type'(csr_index))
            kcr_pkg::REG_MODIFIER:  mod_code_ff <= csr_write_data;
            kcr_pkg::REG_VOL_DOWN:  dn_code_ff  <= csr_write_data;
            kcr_pkg::REG_VOL_UP:    up_code_ff  <= csr_write_data;
            kcr_pkg::REG_POWER:     pw_code_ff  <= csr_write_data;
            kcr_pkg::REG_ALT_DOWN:  alt_dn_ff   <= csr_write_data;
            kcr_pkg::REG_ALT_UP:    alt_up_ff   <= csr_write_data;
            kcr_pkg::REG_ALT_POWER: alt_pw_ff   <= csr_write_data;
            kcr_pkg::REG_RESTART:   thr_ff      <= csr_write_data[kcr_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   // First match wins: modifier, volume down, volume up, power.
   assign is_mod = (req_chan.key_code == mod_code_ff);
   assign is_dn  = !is_mod && (req_chan.key_code == dn_code_ff);
   assign is_up  = !is_mod && !is_dn && (req_chan.key_code == up_code_ff);
   assign is_pw  = !is_mod && !is_dn && !is_up && (req_chan.key_code == pw_code_ff);
   assign evt    = (req_chan.event_type == '0) ? kcr_pkg::DEFAULT_TYPE : req_chan.event_type;
   assign thr_s  = $signed({1'b0, thr_ff});

   always_comb begin
      pending_in  = pending_ff;
      chord_in    = chord_ff;
      down_cnt_in = down_cnt_ff;
      pwr_cnt_in  = pwr_cnt_ff;
      push_valid  = accept;
      push_cmd.code          = req_chan.key_code;
      push_cmd.evt           = evt;
      push_cmd.rep           = '0;
      push_cmd.final_value   = req_chan.pressed;
      push_cmd.final_restart = 1'b0;

      if (is_mod) begin
         if (req_chan.pressed) begin
            if (pending_ff < kcr_pkg::PENDING_MAX) begin
               pending_in = pending_ff + 2'd1;
               push_valid = 1'b0;
            end else if (chord_ff) begin
               push_valid = 1'b0;
            end
         end else if (chord_ff) begin
            pending_in = '0;
            chord_in   = 1'b0;
            push_valid = 1'b0;
         end else begin
            // Flush the held-back presses ahead of the release.
            push_cmd.rep = (pending_ff > kcr_pkg::FLUSH_MAX) ? kcr_pkg::FLUSH_MAX : pending_ff;
            pending_in   = '0;
         end
      end else if (is_dn || is_up || is_pw) begin
         if (is_up) begin
            down_cnt_in = '0;
            pwr_cnt_in  = '0;
         end else if (req_chan.pressed) begin
            if (is_dn) begin
               if (down_cnt_ff != 8'sd127) down_cnt_in = down_cnt_ff + 8'sd1;
            end else begin
               if (pwr_cnt_ff != 8'sd127) pwr_cnt_in = pwr_cnt_ff + 8'sd1;
            end
            if ((down_cnt_in > thr_s) && (pwr_cnt_in > thr_s)) begin
               push_cmd.final_restart = 1'b1;
               down_cnt_in = '0;
               pwr_cnt_in  = '0;
            end
         end else begin
            if (is_dn) begin
               if (down_cnt_ff != -8'sd128) down_cnt_in = down_cnt_ff - 8'sd1;
            end else begin
               if (pwr_cnt_ff != -8'sd128) pwr_cnt_in = pwr_cnt_ff - 8'sd1;
            end
         end

         if ((pending_ff != '0) || chord_ff) begin
            push_cmd.code = is_dn ? alt_dn_ff : (is_up ? alt_up_ff : alt_pw_ff);
            if (req_chan.pressed) chord_in = 1'b1;
         end else begin
            chord_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         chord_ff    <= 1'b0;
         down_cnt_ff <= '0;
         pwr_cnt_ff  <= '0;
      end else if (accept) begin
         pending_ff  <= pending_in;
         chord_ff    <= chord_in;
         down_cnt_ff <= down_cnt_in;
         pwr_cnt_ff  <= pwr_cnt_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/kcr_queue.sv */
// Short command queue between the front end and the result sequencer.
`default_nettype none
module kcr_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire kcr_pkg::cmd_type     push_cmd,
   output logic                      push_ready,
   input  wire logic                 pop,
   output kcr_pkg::queue_head_type   head
);

   kcr_pkg::cmd_type entries_ff [kcr_pkg::QUEUE_DEPTH];
   logic [kcr_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [kcr_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != kcr_pkg::QCNT_W'(kcr_pkg::QUEUE_DEPTH));
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/kcr_back.sv */
// Back end: expands one queued command into its results in the output register, one per cycle unless it stalls.
`default_nettype none
module kcr_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire kcr_pkg::queue_head_type head,
   output logic                         pop,
   kcr_rsp_if.source                    rsp_chan
);

   logic [kcr_pkg::REP_W-1:0]  step_ff, step_in;
   logic                       valid_ff, valid_in;
   logic [kcr_pkg::CODE_W-1:0] code_ff;
   logic [kcr_pkg::TYPE_W-1:0] type_ff;
   logic                       value_ff, restart_ff, last_ff;
   logic                       load, fire, is_final;

   assign load     = !valid_ff || rsp_chan.ready;
   assign fire     = load && head.valid;
   assign is_final = (step_ff == head.cmd.rep);
   assign pop      = fire && is_final;

   always_comb begin
      valid_in = load ? head.valid : valid_ff;
      step_in  = step_ff;
      if (fire) step_in = is_final ? '0 : step_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   // Flushed presses come first, then the final result carrying last.
   always_ff @(posedge clock) begin
      if (fire) begin
         code_ff    <= head.cmd.code;
         type_ff    <= head.cmd.evt;
         value_ff   <= is_final ? head.cmd.final_value : 1'b1;
         restart_ff <= is_final && head.cmd.final_restart;
         last_ff    <= is_final;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.out_code        = code_ff;
   assign rsp_chan.out_type        = type_ff;
   assign rsp_chan.out_value       = value_ff;
   assign rsp_chan.restart_request = restart_ff;
   assign rsp_chan.last            = last_ff;

endmodule
`default_nettype wire

/* hdl/key_chord_remap_and_reset_combo.sv */
// The first response of a request is registered in the queue, then in the output register.
// Throughput, while the output is ready: one request per cycle while each yields at most one
// response; a modifier release that flushes held-back presses yields up to three responses,
// one per cycle, set by the response sequencer. A two-entry queue decouples request and response
// sides. Reset (synchronous, active high) restores register defaults and clears all key state.
`default_nettype none
module key_chord_remap_and_reset_combo (
   input  wire logic                        clock,
   input  wire logic                        reset,
   kcr_req_if.sink                          req_chan,
   kcr_rsp_if.source                        rsp_chan,
   input  wire logic                        csr_write_enable,
   input  wire logic [2:0]                  csr_index,
   input  wire logic [kcr_pkg::CODE_W-1:0]  csr_write_data
);

   // The front end accepts a request whenever the queue has room. It classifies the
   // key, updates the pending presses, the chord flag and the two restart counters,
   // and turns the request into one command: a number of flushed modifier presses
   // followed by one final response. Requests that produce no response (held-back modifier
   // presses, a press on a full store in a chord, a release after a chord) never reach the queue.
   logic             push_valid;
   logic             push_ready;
   kcr_pkg::cmd_type push_cmd;

   // The back end pops a command as its final response is loaded into the output
   // register; a stalled output blocks the front only once the queue is full.
   logic                     pop;
   kcr_pkg::queue_head_type  head;

   kcr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_ready       (push_ready),
      .push_valid       (push_valid),
      .push_cmd         (push_cmd)
   );

   kcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head)
   );

   kcr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

/* verif/key_chord_remap_and_reset_combo_tb.sv */
// Self-checking testbench for the key chord remapper: predicted key events against the block.
module key_chord_remap_and_reset_combo_tb;
   import kcr_pkg::*;

   // Generous bound on the whole run; the slowest legal run needs far fewer cycles.
   localparam int LIMIT_CYCLES = 400000;
   // Cycles allowed after the last expected response for requests that emit nothing.
   localparam int DRAIN_CYCLES = 8;
   // Length of the one long receiver hold-off, and the response count that starts it.
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int LONG_HOLD_AFTER  = 30;
   // The closing phase runs until the total reaches this many requests.
   localparam int TOTAL_REQUESTS = 375;

   // One emitted key event, as seen on the response channel.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [TYPE_W-1:0] etype;
      logic              value;
      logic              restart;
      logic              last;
   } key_event_type;

   // How a raw key code is classed; the first match in this order wins.
   typedef enum int {
      KEY_MODIFIER,
      KEY_VOL_DOWN,
      KEY_VOL_UP,
      KEY_POWER,
      KEY_OTHER
   } key_class_type;

   // The chord tracker keeps its own copy of the registers and the key state, works out
   // the events that each accepted request must produce, and checks the responses
   // against them in order.
   class chord_tracker;
      logic [CODE_W-1:0] regs [8];
      logic [REP_W-1:0]  held_presses;
      bit                chord_seen;
      int                down_count;
      int                power_count;
      key_event_type     expected_events[$];
      key_event_type     batch[$];
      int                mismatches;
      int                checked;
      int                chords;
      int                swallowed;
      int                restarts;
      int                saturations;

      function new();
         regs[REG_MODIFIER]  = 10'd158;
         regs[REG_VOL_DOWN]  = 10'd102;
         regs[REG_VOL_UP]    = 10'd108;
         regs[REG_POWER]     = 10'd139;
         regs[REG_ALT_DOWN]  = 10'd114;
         regs[REG_ALT_UP]    = 10'd115;
         regs[REG_ALT_POWER] = 10'd217;
         regs[REG_RESTART]   = 10'd10;
         held_presses = '0;
         chord_seen   = 1'b0;
         down_count   = 0;
         power_count  = 0;
         mismatches   = 0;
         checked      = 0;
         chords       = 0;
         swallowed    = 0;
         restarts     = 0;
         saturations  = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CODE_W-1:0] value);
         if (idx == REG_RESTART)
            regs[idx] = {3'b000, value[THR_W-1:0]};
         else
            regs[idx] = value;
      endfunction

      function key_class_type classify(logic [CODE_W-1:0] code);
         if (code == regs[REG_MODIFIER]) return KEY_MODIFIER;
         if (code == regs[REG_VOL_DOWN]) return KEY_VOL_DOWN;
         if (code == regs[REG_VOL_UP])   return KEY_VOL_UP;
         if (code == regs[REG_POWER])    return KEY_POWER;
         return KEY_OTHER;
      endfunction

      // The press counters are signed 8-bit values that stick at their ends.
      function int clamp_count(int v);
         if (v > 127) begin
            saturations++;
            return 127;
         end
         if (v < -128) begin
            saturations++;
            return -128;
         end
         return v;
      endfunction

      function void add_event(logic [CODE_W-1:0] code, logic [TYPE_W-1:0] etype,
                              logic value, logic restart);
         key_event_type ev;
         ev.code    = code;
         ev.etype   = etype;
         ev.value   = value;
         ev.restart = restart;
         ev.last    = 1'b0;
         batch.push_back(ev);
      endfunction

      function void accept_report(logic [CODE_W-1:0] code, logic [TYPE_W-1:0] etype_in,
                                  logic down);
         logic [TYPE_W-1:0] etype;
         logic [CODE_W-1:0] emit;
         logic              restart;
         int                flush;
         int                threshold;
         key_class_type     kind;
         key_event_type     ev;
         batch.delete();
         etype     = (etype_in == '0) ? DEFAULT_TYPE : etype_in;
         threshold = int'(regs[REG_RESTART]);
         kind      = classify(code);
         case (kind)
            KEY_MODIFIER: begin
               if (down) begin
                  if (held_presses < PENDING_MAX)
                     held_presses++;
                  else if (!chord_seen)
                     add_event(code, etype, 1'b1, 1'b0);
               end else if (chord_seen) begin
                  held_presses = '0;
                  chord_seen   = 1'b0;
                  swallowed++;
               end else begin
                  flush = (held_presses > FLUSH_MAX) ? int'(FLUSH_MAX) : int'(held_presses);
                  repeat (flush) add_event(code, etype, 1'b1, 1'b0);
                  held_presses = '0;
                  add_event(code, etype, 1'b0, 1'b0);
               end
            end
            KEY_OTHER: add_event(code, etype, down, 1'b0);
            default: begin
               restart = 1'b0;
               emit    = code;
               if (kind == KEY_VOL_UP) begin
                  down_count  = 0;
                  power_count = 0;
               end else if (down) begin
                  if (kind == KEY_VOL_DOWN)
                     down_count = clamp_count(down_count + 1);
                  else
                     power_count = clamp_count(power_count + 1);
                  if (down_count > threshold && power_count > threshold) begin
                     restart     = 1'b1;
                     down_count  = 0;
                     power_count = 0;
                     restarts++;
                  end
               end else begin
                  if (kind == KEY_VOL_DOWN)
                     down_count = clamp_count(down_count - 1);
                  else
                     power_count = clamp_count(power_count - 1);
               end
               if (held_presses != '0 || chord_seen) begin
                  emit = (kind == KEY_VOL_DOWN) ? regs[REG_ALT_DOWN] :
                         (kind == KEY_VOL_UP)   ? regs[REG_ALT_UP]   : regs[REG_ALT_POWER];
                  if (down) begin
                     chord_seen = 1'b1;
                     chords++;
                  end
               end else begin
                  chord_seen = 1'b0;
               end
               add_event(emit, etype, down, restart);
            end
         endcase
         if (batch.size() > 0) begin
            ev = batch.pop_back();
            ev.last = 1'b1;
            batch.push_back(ev);
         end
         foreach (batch[i]) expected_events.push_back(batch[i]);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("MISMATCH %0d: %s", mismatches, what);
      endtask

      task check_event(key_event_type got);
         key_event_type want;
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("response code %0d value %0d with nothing outstanding",
                                      got.code, got.value));
            return;
         end
         want = expected_events.pop_front();
         checked++;
         if (got.code != want.code)
            report_mismatch($sformatf("response %0d: code %0d, want %0d",
                                      checked, got.code, want.code));
         if (got.etype != want.etype)
            report_mismatch($sformatf("response %0d: type %0d, want %0d",
                                      checked, got.etype, want.etype));
         if (got.value != want.value)
            report_mismatch($sformatf("response %0d: value %0d, want %0d",
                                      checked, got.value, want.value));
         if (got.restart != want.restart)
            report_mismatch($sformatf("response %0d: restart %0d, want %0d",
                                      checked, got.restart, want.restart));
         if (got.last != want.last)
            report_mismatch($sformatf("response %0d: last %0d, want %0d",
                                      checked, got.last, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_write_enable;
   logic [2:0]          csr_index;
   logic [CODE_W-1:0]   csr_write_data;

   kcr_req_if req_chan ();
   kcr_rsp_if rsp_chan ();

   key_chord_remap_and_reset_combo u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   chord_tracker      sb;
   int                requests_sent;
   int                cycle_count = 0;
   // While set, the request side inserts no idle cycles and the response side starts no random stalls.
   bit                steady;
   logic [CODE_W-1:0] reg_plan [8];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a hung handshake or a lost response ends the run as a failure.
   initial begin : watchdog
      wait (cycle_count >= LIMIT_CYCLES);
      $display("Run stopped after %0d cycles with %0d responses outstanding.",
               cycle_count, sb.expected_events.size());
      $display("key_chord_remap_and_reset_combo verification failed");
      $finish;
   end

   // Idle lengths: mostly none, often a few cycles, now and then a long gap.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Event types lean toward zero (the default type) and one, with the full range mixed in.
   function automatic logic [TYPE_W-1:0] pick_type();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return '0;
      if (r < 65) return DEFAULT_TYPE;
      return TYPE_W'($urandom_range(0, 31));
   endfunction

   // A key code that matches none of the four configured keys.
   function automatic logic [CODE_W-1:0] plain_code();
      logic [CODE_W-1:0] code;
      do
         code = CODE_W'($urandom_range(0, 767));
      while (sb.classify(code) != KEY_OTHER);
      return code;
   endfunction

   // One of the keys that remap while the modifier is down; volume up is rarer since
   // it wipes out the restart counters.
   function automatic logic [CODE_W-1:0] chord_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return sb.regs[REG_VOL_DOWN];
      if (r < 55) return sb.regs[REG_VOL_UP];
      return sb.regs[REG_POWER];
   endfunction

   // Offers one request and returns at the edge where it is accepted. Valid is lowered
   // only when an idle gap follows, so back-to-back requests never see valid dropped and
   // raised within the same time step.
   task automatic send_request(input logic [CODE_W-1:0] code, input logic [TYPE_W-1:0] etype,
                               input logic down);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.key_code   <= code;
      req_chan.event_type <= etype;
      req_chan.pressed    <= down;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.accept_report(code, etype, down);
      requests_sent++;
   endtask

   // Stops offering, waits for every expected response, then lets the pipeline settle so
   // that requests which emit nothing are surely finished.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (sb.expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes every register from reg_plan, one per cycle, with the block idle.
   task automatic load_registers();
      csr_index_type idx;
      idx = idx.first();
      repeat (idx.num()) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx;
         csr_write_data   <= reg_plan[idx];
         @(posedge clock);
         sb.set_reg(idx, reg_plan[idx]);
         idx = idx.next();
      end
      csr_write_enable <= 1'b0;
   endtask

   // One user gesture with random content. Most are well formed (a modifier hold with
   // chord keys inside, a volume-down/power combination, a plain key tap); the rest are
   // stray reports such as a release without a press.
   task automatic play_gesture();
      int                choice;
      int                n;
      int                k;
      logic [CODE_W-1:0] key;
      choice = $urandom_range(0, 99);
      steady = ($urandom_range(0, 4) == 0);
      if (choice < 35) begin
         n = $urandom_range(1, 4);
         repeat (n) send_request(sb.regs[REG_MODIFIER], pick_type(), 1'b1);
         n = $urandom_range(0, 3);
         repeat (n) begin
            key = chord_key();
            k = $urandom_range(1, 3);
            repeat (k) send_request(key, pick_type(), 1'b1);
            if ($urandom_range(0, 3) != 0) send_request(key, pick_type(), 1'b0);
         end
         // Further modifier presses after the chord keys land on a full pending store once two are held back.
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_request(sb.regs[REG_MODIFIER], pick_type(), 1'b1);
         if ($urandom_range(0, 9) != 0)
            send_request(sb.regs[REG_MODIFIER], pick_type(), 1'b0);
      end else if (choice < 60) begin
         n = $urandom_range(4, 14);
         repeat (n) begin
            key = ($urandom_range(0, 1) == 1) ? sb.regs[REG_VOL_DOWN] : sb.regs[REG_POWER];
            send_request(key, pick_type(), $urandom_range(0, 4) != 0);
         end
      end else if (choice < 68) begin
         send_request(sb.regs[REG_VOL_UP], pick_type(), 1'b1);
         send_request(sb.regs[REG_VOL_UP], pick_type(), 1'b0);
      end else if (choice < 85) begin
         key = plain_code();
         n = $urandom_range(1, 3);
         repeat (n) send_request(key, pick_type(), 1'b1);
         send_request(key, pick_type(), 1'b0);
      end else begin
         k = $urandom_range(0, 4);
         key = (k == 4) ? CODE_W'($urandom_range(0, 767)) : sb.regs[k];
         send_request(key, TYPE_W'($urandom_range(0, 31)), $urandom_range(0, 1) == 1);
      end
   endtask

   // Drives one counter key in one direction far enough to hit its end stop, with the
   // odd unrelated key mixed in.
   task automatic sweep_counter(input logic [CODE_W-1:0] key, input logic down,
                                input int count);
      repeat (count) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 19) == 0) send_request(plain_code(), pick_type(), 1'b1);
         send_request(key, pick_type(), down);
      end
   endtask

   // Response side: checks every accepted response and stalls at random. Once, after a
   // fair number of responses, it holds ready low for a long stretch while the sender
   // keeps offering, so the block's queue fills and it pushes back on requests.
   initial begin : response_side
      int            stall_left;
      bit            long_hold_done;
      key_event_type got;
      stall_left     = 0;
      long_hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.code    = rsp_chan.out_code;
            got.etype   = rsp_chan.out_type;
            got.value   = rsp_chan.out_value;
            got.restart = rsp_chan.restart_request;
            got.last    = rsp_chan.last;
            sb.check_event(got);
         end
         if (!long_hold_done && sb.checked >= LONG_HOLD_AFTER) begin
            stall_left     = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Request side and run control.
   initial begin : request_side
      logic [CODE_W-1:0] mod_key;
      logic [CODE_W-1:0] down_key;
      logic [CODE_W-1:0] up_key;
      logic [CODE_W-1:0] pwr_key;
      sb            = new();
      requests_sent = 0;
      steady        = 1'b0;
      req_chan.valid      <= 1'b0;
      req_chan.key_code   <= '0;
      req_chan.event_type <= '0;
      req_chan.pressed    <= 1'b0;
      csr_write_enable    <= 1'b0;
      csr_index           <= REG_MODIFIER;
      csr_write_data      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the registers at their reset values.
      mod_key  = sb.regs[REG_MODIFIER];
      down_key = sb.regs[REG_VOL_DOWN];
      up_key   = sb.regs[REG_VOL_UP];
      pwr_key  = sb.regs[REG_POWER];
      // Plain keys at the code and type extremes; type zero turns into the default type.
      send_request(10'd0, 5'd0, 1'b1);
      send_request(10'd767, 5'd31, 1'b0);
      // Two held-back presses, a third press with the store full, then a release that
      // flushes both ahead of itself.
      send_request(mod_key, 5'd1, 1'b1);
      send_request(mod_key, 5'd1, 1'b1);
      send_request(mod_key, 5'd1, 1'b1);
      send_request(mod_key, 5'd1, 1'b0);
      // A chord on volume down: remapped presses and release, a press on a full store
      // with the chord active (nothing out), and a swallowed modifier release.
      send_request(mod_key, 5'd0, 1'b1);
      send_request(down_key, 5'd1, 1'b1);
      send_request(down_key, 5'd1, 1'b1);
      send_request(down_key, 5'd1, 1'b0);
      send_request(mod_key, 5'd1, 1'b1);
      send_request(mod_key, 5'd1, 1'b1);
      send_request(mod_key, 5'd1, 1'b0);
      // Power on its own, then volume up, which clears both counters either way.
      send_request(pwr_key, 5'd1, 1'b1);
      send_request(up_key, 5'd1, 1'b1);
      send_request(up_key, 5'd1, 1'b0);
      // Volume up and power remapped inside one hold, then the release swallowed.
      send_request(mod_key, 5'd1, 1'b1);
      send_request(up_key, 5'd2, 1'b1);
      send_request(pwr_key, 5'd3, 1'b1);
      send_request(pwr_key, 5'd3, 1'b0);
      send_request(mod_key, 5'd1, 1'b0);
      // Release with nothing held back, then with a single held-back press.
      send_request(mod_key, 5'd1, 1'b0);
      send_request(mod_key, 5'd1, 1'b1);
      send_request(mod_key, 5'd1, 1'b0);

      // Random gestures at the reset settings; the long receiver hold-off lands here.
      while (requests_sent < 55) play_gesture();
      wait_idle();

      // Volume up shadowed by volume down, alternate codes at the extremes, and a zero
      // threshold so that restart requests come often.
      reg_plan = '{10'd158, 10'd102, 10'd102, 10'd139, 10'd0, 10'd767, 10'd767, 10'd0};
      load_registers();
      while (requests_sent < 75) play_gesture();
      wait_idle();

      // Key codes at the extremes, volume up shadowed by the modifier, and a threshold one below the
      // largest. Volume down is run into its low stop and power into its high stop;
      // neither can reach the threshold while the other sits at the bottom.
      reg_plan = '{10'd767, 10'd0, 10'd767, 10'd512, 10'd767, 10'd0, 10'd0, 10'd126};
      load_registers();
      steady = 1'b0;
      send_request(sb.regs[REG_MODIFIER], pick_type(), 1'b0);
      sweep_counter(sb.regs[REG_VOL_DOWN], 1'b0, 130);
      sweep_counter(sb.regs[REG_POWER], 1'b1, 130);
      wait_idle();

      // Ordinary distinct codes with a small threshold to finish.
      reg_plan = '{10'd300, 10'd301, 10'd302, 10'd303, 10'd1, 10'd2, 10'd3, 10'd3};
      load_registers();
      while (requests_sent < TOTAL_REQUESTS) play_gesture();
      wait_idle();

      $display("Checked %0d responses from %0d requests over four register settings.",
               sb.checked, requests_sent);
      $display("Chord presses %0d, swallowed releases %0d, restarts %0d, saturations %0d.",
               sb.chords, sb.swallowed, sb.restarts, sb.saturations);
      if (sb.mismatches == 0) begin
         $display("key_chord_remap_and_reset_combo verification clean");
      end else begin
         $display("key_chord_remap_and_reset_combo verification failed");
      end
      $finish;
   end

endmodule
